// File: hdl/radial_falloff_point_displacement_assert.svh
// assertion macros for the radial falloff displacement checker
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef RADIAL_FALLOFF_POINT_DISPLACEMENT_ASSERT_SVH
`define RADIAL_FALLOFF_POINT_DISPLACEMENT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RFPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfpd assertion failed");

// consequent must hold in the cycle after the antecedent
`define RFPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfpd assertion failed");

`endif

// File: hdl/rfpd_pkg.sv
// shared types, constants and helpers for the radial falloff displacement block
// no dependencies
package rfpd_pkg;

    localparam int COORD_W    = 22;
    localparam int DIFF_W     = 23;
    localparam int RADIUS_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int TDATA_W    = 72;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 22'sh1FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 22'sh200000;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd1024;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd6;

    typedef logic signed [COORD_W-1:0] coord_t;

    // per-point payload that rides along the square root and divide stages
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   in_zone;
        logic   tail;
    } side_t;

    // clamp a widened sum back to the coordinate range
    function automatic coord_t sat_coord(input logic signed [COORD_W+1:0] v);
        coord_t r;
        if (v > $signed({{2{COORD_MAX[COORD_W-1]}}, COORD_MAX}))
            r = COORD_MAX;
        else if (v < $signed({{2{COORD_MIN[COORD_W-1]}}, COORD_MIN}))
            r = COORD_MIN;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

// File: hdl/radial_falloff_point_displacement.sv
// top level of the radial falloff point displacement pipeline
// depends on rfpd_pkg and rfpd_sqrt_pipe
//
// Moves each streamed point that is not pinned and lies strictly inside the
// falloff radius by sqrt(1 - d/R) times half of (goal - anchor), saturating
// to the coordinate range; other points pass unchanged. One point is taken
// every clock while the output side keeps up. The pipeline holds three stages
// for differences, squares and the radius compare, sixteen stages of distance
// square root, F + 1 stages of restoring divide, F + 1 stages of falloff square
// root, one multiply stage and the output register. A stall on the output holds
// the whole pipeline.
// Configuration must be written while no point is in flight.
module radial_falloff_point_displacement #(
    parameter int FALLOFF_FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfpd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rfpd_pkg::TDATA_W-1:0]    s_tdata,   // point_x, point_y, point_z, pad
    input  logic                            s_tuser,   // point_pinned
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rfpd_pkg::TDATA_W-1:0]    m_tdata,   // moved_x, moved_y, moved_z, pad
    output logic                            m_tuser,   // was_moved
    output logic                            m_tlast
);

    import rfpd_pkg::*;

    localparam int F      = FALLOFF_FRAC_BITS;
    localparam int QW     = F + 1;
    localparam int MAG_W  = DIFF_W + QW;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int RR_W   = 2 * RADIUS_W;
    localparam int SIDE_W = $bits(side_t);

    // pipeline advances unless a finished transaction is waiting
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // configuration registers
    coord_t              anchor_reg [3];
    coord_t              goal_reg   [3];
    logic [RADIUS_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                anchor_reg[k] <= '0;
                goal_reg[k]   <= '0;
            end
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANCHOR_X: anchor_reg[0] <= cfg_data[COORD_W-1:0];
                REG_ANCHOR_Y: anchor_reg[1] <= cfg_data[COORD_W-1:0];
                REG_ANCHOR_Z: anchor_reg[2] <= cfg_data[COORD_W-1:0];
                REG_GOAL_X:   goal_reg[0]   <= cfg_data[COORD_W-1:0];
                REG_GOAL_Y:   goal_reg[1]   <= cfg_data[COORD_W-1:0];
                REG_GOAL_Z:   goal_reg[2]   <= cfg_data[COORD_W-1:0];
                REG_RADIUS:   radius_reg    <= cfg_data[RADIUS_W-1:0];
                default:      ;
            endcase
        end
    end

    // drag vector magnitude and sign per axis, follows the configuration
    logic [DIFF_W-1:0] dmag_reg [3];
    logic              dneg_reg [3];

    for (genvar k = 0; k < 3; k++) begin : g_drag
        logic signed [DIFF_W-1:0] delta_next;
        assign delta_next = DIFF_W'(goal_reg[k]) - DIFF_W'(anchor_reg[k]);
        always_ff @(posedge clk)
        begin
            dneg_reg[k] <= delta_next[DIFF_W-1];
            dmag_reg[k] <= delta_next[DIFF_W-1] ? DIFF_W'(-delta_next) : delta_next;
        end
    end

    // stage 1: capture point, offsets from the anchor
    logic                     s1_valid_reg;
    coord_t                   s1_p_reg    [3];
    logic signed [DIFF_W-1:0] s1_diff_reg [3];
    logic                     s1_pinned_reg;
    logic                     s1_tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_p_reg[k]    <= s_tdata[k*COORD_W +: COORD_W];
                s1_diff_reg[k] <= DIFF_W'($signed(s_tdata[k*COORD_W +: COORD_W]))
                                - DIFF_W'(anchor_reg[k]);
            end
            s1_pinned_reg <= s_tuser;
            s1_tail_reg   <= s_tlast;
        end
    end

    // stage 2: squares and radius squared
    logic              s2_valid_reg;
    coord_t            s2_p_reg  [3];
    logic [SQ_W-1:0]   s2_sq_reg [3];
    logic [RR_W-1:0]   s2_rr_reg;
    logic              s2_pinned_reg;
    logic              s2_tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_p_reg[k]  <= s1_p_reg[k];
                s2_sq_reg[k] <= SQ_W'(s1_diff_reg[k] * s1_diff_reg[k]);
            end
            s2_rr_reg     <= RR_W'(radius_reg * radius_reg);
            s2_pinned_reg <= s1_pinned_reg;
            s2_tail_reg   <= s1_tail_reg;
        end
    end

    // stage 3: squared distance and in-radius test
    logic [SQ_W+1:0] d2_next;
    logic            s3_valid_reg;
    logic [RR_W-1:0] s3_d2_reg;
    side_t           s3_side_reg;

    assign d2_next = (SQ_W+2)'(s2_sq_reg[0]) + (SQ_W+2)'(s2_sq_reg[1])
                   + (SQ_W+2)'(s2_sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_d2_reg           <= d2_next[RR_W-1:0];
            s3_side_reg.x       <= s2_p_reg[0];
            s3_side_reg.y       <= s2_p_reg[1];
            s3_side_reg.z       <= s2_p_reg[2];
            s3_side_reg.in_zone <= !s2_pinned_reg && (d2_next < (SQ_W+2)'(s2_rr_reg));
            s3_side_reg.tail    <= s2_tail_reg;
        end
    end

    // distance square root, only meaningful for points inside the radius
    logic                sq1_valid;
    logic [RADIUS_W-1:0] sq1_root;
    logic [SIDE_W-1:0]   sq1_side;

    rfpd_sqrt_pipe #(
        .W  (RADIUS_W),
        .PW (SIDE_W)
    ) u_sqrt_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .in_rad    (s3_d2_reg),
        .in_side   (s3_side_reg),
        .out_valid (sq1_valid),
        .out_root  (sq1_root),
        .out_side  (sq1_side)
    );

    // restoring divide (R - d) * 2^F / R, first step handles the integer bit
    logic                dv_valid_reg [F+1];
    logic [RADIUS_W-1:0] dv_rem_reg   [F+1];
    logic [QW-1:0]       dv_q_reg     [F+1];
    logic [SIDE_W-1:0]   dv_side_reg  [F+1];

    logic [RADIUS_W-1:0] dv_a_next;
    logic                dv_top_next;

    assign dv_a_next   = radius_reg - sq1_root;
    assign dv_top_next = (dv_a_next >= radius_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= sq1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0]  <= dv_top_next ? (dv_a_next - radius_reg) : dv_a_next;
            dv_q_reg[0]    <= QW'(dv_top_next);
            dv_side_reg[0] <= sq1_side;
        end
    end

    for (genvar j = 1; j <= F; j++) begin : g_div
        logic [RADIUS_W:0] sh;
        logic              ge;
        assign sh = {dv_rem_reg[j-1], 1'b0};
        assign ge = (sh >= {1'b0, radius_reg});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[j]  <= ge ? RADIUS_W'(sh - {1'b0, radius_reg})
                                     : RADIUS_W'(sh);
                dv_q_reg[j]    <= {dv_q_reg[j-1][QW-2:0], ge};
                dv_side_reg[j] <= dv_side_reg[j-1];
            end
        end
    end

    // falloff square root, sqrt(ffq * 2^F)
    logic [2*QW-1:0]   sq2_rad;
    logic              sq2_valid;
    logic [QW-1:0]     sq2_root;
    logic [SIDE_W-1:0] sq2_side;

    assign sq2_rad = {1'b0, dv_q_reg[F], {F{1'b0}}};

    rfpd_sqrt_pipe #(
        .W  (QW),
        .PW (SIDE_W)
    ) u_sqrt_falloff (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (dv_valid_reg[F]),
        .in_rad    (sq2_rad),
        .in_side   (dv_side_reg[F]),
        .out_valid (sq2_valid),
        .out_root  (sq2_root),
        .out_side  (sq2_side)
    );

    // scale the drag magnitude by the falloff factor
    logic             mu_valid_reg;
    logic [MAG_W-1:0] mu_mag_reg [3];
    side_t            mu_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mu_valid_reg <= sq2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mu_mag_reg[k] <= MAG_W'(dmag_reg[k] * sq2_root);
            end
            mu_side_reg <= sq2_side;
        end
    end

    // round half away from zero, apply sign, add and saturate
    coord_t res_next [3];
    coord_t mu_p [3];

    assign mu_p[0] = mu_side_reg.x;
    assign mu_p[1] = mu_side_reg.y;
    assign mu_p[2] = mu_side_reg.z;

    for (genvar k = 0; k < 3; k++) begin : g_apply
        logic [MAG_W-1:0]           rsum;
        logic [DIFF_W-1:0]          off;
        logic signed [COORD_W+1:0]  moved;
        assign rsum  = mu_mag_reg[k] + (MAG_W'(1) << F);
        assign off   = DIFF_W'(rsum >> (F + 1));
        assign moved = dneg_reg[k] ? ((COORD_W+2)'(mu_p[k]) - (COORD_W+2)'(off))
                                   : ((COORD_W+2)'(mu_p[k]) + (COORD_W+2)'(off));
        assign res_next[k] = mu_side_reg.in_zone ? sat_coord(moved) : mu_p[k];
    end

    // output register
    logic                 out_valid_reg;
    logic [TDATA_W-1:0]   out_data_reg;
    logic                 out_moved_reg;
    logic                 out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= mu_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg  <= {{(TDATA_W-3*COORD_W){1'b0}}, res_next[2], res_next[1],
                              res_next[0]};
            out_moved_reg <= mu_side_reg.in_zone;
            out_last_reg  <= mu_side_reg.tail;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_moved_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hdl/rfpd_sqrt_pipe.sv
// pipelined integer square root, one result bit per register stage
// standalone, carries an opaque payload alongside the root
module rfpd_sqrt_pipe #(
    parameter int W  = 16,
    parameter int PW = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [2*W-1:0] in_rad,
    input  logic [PW-1:0]  in_side,
    output logic           out_valid,
    output logic [W-1:0]   out_root,
    output logic [PW-1:0]  out_side
);

    localparam int RW = W + 2;
    localparam int SW = W + 4;

    logic           v_reg    [W];
    logic [RW-1:0]  rem_reg  [W];
    logic [W-1:0]   root_reg [W];
    logic [2*W-1:0] rad_reg  [W];
    logic [PW-1:0]  side_reg [W];

    for (genvar k = 0; k < W; k++) begin : g_step
        logic           prev_v;
        logic [RW-1:0]  prev_rem;
        logic [W-1:0]   prev_root;
        logic [2*W-1:0] prev_rad;
        logic [PW-1:0]  prev_side;
        logic [SW-1:0]  sh;
        logic [SW-1:0]  trial;
        logic           ge;
        logic [RW-1:0]  rem_next;
        logic [W-1:0]   root_next;
        logic [2*W-1:0] rad_next;

        if (k == 0) begin : g_first
            assign prev_v    = in_valid;
            assign prev_rem  = '0;
            assign prev_root = '0;
            assign prev_rad  = in_rad;
            assign prev_side = in_side;
        end else begin : g_rest
            assign prev_v    = v_reg[k-1];
            assign prev_rem  = rem_reg[k-1];
            assign prev_root = root_reg[k-1];
            assign prev_rad  = rad_reg[k-1];
            assign prev_side = side_reg[k-1];
        end

        // bring down two radicand bits and try the next root bit
        assign sh        = {prev_rem, prev_rad[2*W-1 -: 2]};
        assign trial     = {2'b00, prev_root, 2'b01};
        assign ge        = (sh >= trial);
        assign rem_next  = ge ? RW'(sh - trial) : RW'(sh);
        assign root_next = {prev_root[W-2:0], ge};
        assign rad_next  = {prev_rad[2*W-3:0], 2'b00};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= prev_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
                side_reg[k] <= prev_side;
            end
        end
    end

    assign out_valid = v_reg[W-1];
    assign out_root  = root_reg[W-1];
    assign out_side  = side_reg[W-1];

endmodule

// File: hdl/rfpd_checker.sv
// port-level checks for the radial falloff displacement block, with its bind
// depends on radial_falloff_point_displacement_assert.svh and the top level
`include "radial_falloff_point_displacement_assert.svh"

module rfpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // input side is open exactly when the output register can move
    `RFPD_ASSERT_NOW(a_ready_follows_output, 1'b1, s_tready == (!m_tvalid || m_tready))

    // pad bits above the three coordinates stay zero
    `RFPD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[71:66] == 6'd0)

    // a stalled output transaction stays presented
    `RFPD_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

    // and its payload does not change
    `RFPD_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind radial_falloff_point_displacement rfpd_checker u_rfpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/radial_falloff_point_displacement_tb.sv
// testbench for the radial falloff point displacement pipeline
// depends on rfpd_pkg and the radial_falloff_point_displacement top level
`timescale 1ns / 1ps

module radial_falloff_point_displacement_tb;
    import rfpd_pkg::*;

    localparam int FRAC_F    = 16;
    localparam int LATENCY   = 23 + 2 * FRAC_F;
    localparam int CYCLE_CAP = 1000000;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   moved;
        logic   last;
    } displaced_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic s_tuser;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    // shadow copy of the register file
    coord_t anchor_pos [3];
    coord_t goal_pos [3];
    logic [RADIUS_W-1:0] radius;

    displaced_t expected_points [$];
    int send_idle_pct;
    int recv_idle_pct;
    logic hold_active;
    event hold_start;
    int mismatches;
    int checked_points;
    int cycle_count;
    int moved_count;

    radial_falloff_point_displacement dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // expected new position for one point
    function automatic displaced_t displace_point(input coord_t px, input coord_t py,
                                                  input coord_t pz, input logic pinned,
                                                  input logic last);
        displaced_t r;
        longint p [3];
        longint diff;
        longint delta;
        longint unsigned d2;
        longint unsigned rr;
        longint unsigned dq;
        longint unsigned ffq;
        longint unsigned sfq;
        longint unsigned mag;
        longint off;
        longint sum;
        longint res [3];
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        rr = radius;
        d2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            res[k] = p[k];
            diff = p[k] - longint'(anchor_pos[k]);
            d2 += longint'(diff * diff);
        end
        r.moved = 1'b0;
        if (!pinned && d2 < rr * rr)
        begin
            dq = int_sqrt(d2);
            ffq = ((rr - dq) << FRAC_F) / rr;
            sfq = int_sqrt(ffq << FRAC_F);
            r.moved = 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                delta = longint'(goal_pos[k]) - longint'(anchor_pos[k]);
                mag = (delta < 0 ? -delta : delta) * sfq;
                off = longint'((mag + (64'd1 << FRAC_F)) >> (FRAC_F + 1));
                if (delta < 0) off = -off;
                sum = p[k] + off;
                if (sum > 2097151) sum = 2097151;
                if (sum < -2097152) sum = -2097152;
                res[k] = sum;
            end
        end
        r.x = coord_t'(res[0]);
        r.y = coord_t'(res[1]);
        r.z = coord_t'(res[2]);
        r.last = last;
        return r;
    endfunction

    // register write, only while idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ANCHOR_X: anchor_pos[0] = val;
            REG_ANCHOR_Y: anchor_pos[1] = val;
            REG_ANCHOR_Z: anchor_pos[2] = val;
            REG_GOAL_X:   goal_pos[0] = val;
            REG_GOAL_Y:   goal_pos[1] = val;
            REG_GOAL_Z:   goal_pos[2] = val;
            REG_RADIUS:   radius = val[RADIUS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_scene(input coord_t ax, input coord_t ay, input coord_t az,
                             input coord_t gx, input coord_t gy, input coord_t gz,
                             input logic [RADIUS_W-1:0] rad);
        write_reg(REG_ANCHOR_X, ax);
        write_reg(REG_ANCHOR_Y, ay);
        write_reg(REG_ANCHOR_Z, az);
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        write_reg(REG_GOAL_Z, gz);
        write_reg(REG_RADIUS, {6'd0, rad});
    endtask

    // one point transaction, with random gap before it
    task automatic send_point(input coord_t px, input coord_t py, input coord_t pz,
                              input logic pinned, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(TDATA_W - 3 * COORD_W){1'b0}}, pz, py, px};
        s_tuser <= pinned;
        s_tlast <= last;
        expected_points = {expected_points, displace_point(px, py, pz, pinned, last)};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // wait until the pipeline has drained, then let it settle
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // point near the anchor so the falloff path is exercised
    task automatic send_near(input int spread, input logic last);
        coord_t c [3];
        for (int k = 0; k < 3; k++)
            c[k] = coord_t'(int'(anchor_pos[k]) + int'($urandom_range(2 * spread)) - spread);
        send_point(c[0], c[1], c[2], $urandom_range(7) == 0, last);
    endtask

    task automatic send_noise(input logic last);
        send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                   1'($urandom_range(1)), last);
    endtask

    task automatic test_reset_defaults;
        // reset radius with zero goal: inside points flag as moved, no offset
        send_point('0, '0, '0, 1'b0, 1'b0);
        send_point(22'sd1023, '0, '0, 1'b0, 1'b0);
        send_point(22'sd1024, '0, '0, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_directed;
        set_scene(22'sd1000, -22'sd2000, 22'sd500, 22'sd9000, 22'sd4000, -22'sd7000,
                  16'd4096);
        // anchor itself, pinned anchor, edge of radius, just inside
        send_point(22'sd1000, -22'sd2000, 22'sd500, 1'b0, 1'b0);
        send_point(22'sd1000, -22'sd2000, 22'sd500, 1'b1, 1'b0);
        send_point(22'sd5096, -22'sd2000, 22'sd500, 1'b0, 1'b0);
        send_point(22'sd5095, -22'sd2000, 22'sd500, 1'b0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1);
        drain();
        // anchors and goals at opposite ends of the coordinate range, largest radius
        set_scene(COORD_MAX - 22'sd10, COORD_MIN + 22'sd10, 22'sd0,
                  COORD_MIN, COORD_MAX, 22'sd0, 16'hFFFF);
        send_point(COORD_MAX, COORD_MIN, 22'sd0, 1'b0, 1'b0);
        send_point(COORD_MAX - 22'sd10, COORD_MIN + 22'sd10, 22'sd0, 1'b0, 1'b0);
        drain();
        set_scene(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                  16'hFFFF);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        send_point(COORD_MIN + 22'sd100, COORD_MAX, COORD_MIN, 1'b0, 1'b1);
        drain();
        // smallest radius: only the anchor itself is inside
        set_scene(22'sd0, 22'sd0, 22'sd0, -22'sd3, 22'sd1, 22'sd2, 16'd1);
        send_point(22'sd0, 22'sd0, 22'sd0, 1'b0, 1'b0);
        send_point(22'sd1, 22'sd0, 22'sd0, 1'b0, 1'b1);
        drain();
        // out of range index must leave registers alone
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= 3'd7;
        cfg_data <= 22'h3FFFFF;
        @(posedge clk);
        cfg_we <= 1'b0;
        send_point(22'sd0, 22'sd0, 22'sd0, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_random(input int n_points, input int sidle, input int ridle);
        int spread;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int i = 0; i < n_points; i++)
        begin
            if (i % 60 == 0)
            begin
                drain();
                set_scene(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                          ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535))
                                                   : 16'($urandom_range(1, 4096)));
            end
            spread = radius + 4;
            if ($urandom_range(9) < 7) send_near(spread, $urandom_range(15) == 0);
            else send_noise(1'($urandom_range(1)));
        end
        drain();
    endtask

    task automatic test_backpressure;
        // receiver holds off long while points keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> hold_start;
        for (int i = 0; i < 120; i++) send_near(radius + 4, i == 119);
        // pause until all results are back
        drain();
    endtask

    // long receiver hold, counted here
    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(hold_start);
            hold_active = 1'b1;
            repeat (300) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    // output handshake driver
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (hold_active)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        displaced_t exp_pt;
        coord_t gx;
        coord_t gy;
        coord_t gz;
        if (rst_n && m_tvalid && m_tready)
        begin
            gx = m_tdata[COORD_W-1:0];
            gy = m_tdata[2*COORD_W-1:COORD_W];
            gz = m_tdata[3*COORD_W-1:2*COORD_W];
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected point x=%0d y=%0d z=%0d", $time, gx, gy, gz);
                mismatches++;
            end
            else
            begin
                exp_pt = expected_points.pop_front();
                checked_points++;
                if (exp_pt.moved) moved_count++;
                if (gx !== exp_pt.x || gy !== exp_pt.y || gz !== exp_pt.z ||
                    m_tuser !== exp_pt.moved || m_tlast !== exp_pt.last)
                begin
                    $display("%0t: expected %0d %0d %0d moved=%0b last=%0b,",
                             $time, exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.moved,
                             exp_pt.last);
                    $display("    got %0d %0d %0d moved=%0b last=%0b",
                             gx, gy, gz, m_tuser, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mismatches = 0;
        checked_points = 0;
        cycle_count = 0;
        moved_count = 0;
        for (int k = 0; k < 3; k++)
        begin
            anchor_pos[k] = '0;
            goal_pos[k] = '0;
        end
        radius = RADIUS_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        test_random(420, 28, 53);
        test_random(420, 53, 28);
        test_random(300, 0, 0);
        test_backpressure();

        $display("checked %0d points, %0d of them displaced, over random anchors and radii",
                 checked_points, moved_count);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
